@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/cdw_pkg.sv @@
// Types, constants and the segment table for the clock-digit display writer.
// No dependencies.
package cdw_pkg;

  localparam int unsigned DIGITS = 4;
  localparam int unsigned FRAME_COUNT = 6;

  typedef logic [3:0] digit_t;

  localparam logic [7:0] CMD_DATA = 8'h44;
  localparam logic [7:0] CMD_DISP = 8'h88;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] POINT_BIT = 8'h80;

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_TICKS = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SHOW = 1'b1;

  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      default: s = 8'h6f;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/cdw_bcd.sv @@
// Clamps a signed value to at most 99 (to 0 when clear_i is set) and splits it into tens and ones digits.
// Depends on cdw_pkg.
module cdw_bcd import cdw_pkg::*; (
  input  logic signed [7:0] value_i,
  input  logic              clear_i,
  output digit_t            tens_o,
  output digit_t            ones_o
);

  logic [6:0]  sat;
  logic [14:0] prod;
  logic [6:0]  tens_x10;

  always_comb begin
    if (clear_i) begin
      sat = 7'd0;
    end else if (value_i > 8'sd99) begin
      sat = 7'd99;
    end else begin
      sat = value_i[6:0];
    end
    // divide by ten: multiply by 205 / 2048, exact for 0..99
    prod = 15'(sat) * 15'd205;
    tens_o = prod[14:11];
    tens_x10 = {3'b000, tens_o} * 7'd10;
    ones_o = 4'(sat - tens_x10);
  end

endmodule

@@ hdl/clock_digits_two_wire_display_writer_top.sv @@
// Top level of the clock-digit display writer: show/tick sequencer and result register.
// Depends on cdw_pkg and cdw_bcd.
//
// Input channel (in_valid_i / in_ready_o): each transfer is either a tick
// (opcode 0) or a show request (opcode 1) carrying hours, minutes and dp_on.
// A show request taken while idle latches the digits and starts six framed
// writes on the two-wire link; one taken while busy is dropped (accepted 0).
// Ticks step the pin sequence by one phase every ticks_per_phase ticks; in
// the acknowledge wait, a tick with dio_in low moves on.
// Output channel (out_valid_o / out_ready_i): exactly one result per input
// transfer, the pin levels and status after that item.
// The result is registered: it is valid the cycle after its input transfer.
// Throughput: one item per cycle while results are read; the sequencer state
// updates in the cycle of the transfer and the result register frees as it is read.
// A stalled receiver holds the result; input is taken only when the result
// register is empty or being read in the same cycle.
// Reset: idle, both lines high, brightness 2, ticks_per_phase 1.
// Configuration writes via cfg_we_i take effect at once; write only with no
// transfer in flight. Brightness is read as the last command byte goes out.
module clock_digits_two_wire_display_writer_top import cdw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic signed [7:0] hours_i,
  input  logic signed [7:0] minutes_i,
  input  logic              dp_on_i,
  input  logic              dio_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              clk_out_o,
  output logic              dio_out_o,
  output logic              busy_res_o,
  output logic              accepted_o,
  output logic              done_res_o
);

  typedef enum logic [2:0] {
    PART_START = 3'd0,
    PART_BITS  = 3'd1,
    PART_ACK   = 3'd2,
    PART_WAIT  = 3'd3,
    PART_STOP  = 3'd4
  } part_e;

  logic [2:0]  bright_q;
  logic [15:0] tpp_q;

  digit_t      digit_q [DIGITS];
  digit_t      digit_d [DIGITS];
  logic        point_q, point_d;
  logic        active_q, active_d;
  logic [2:0]  frame_q, frame_d;
  logic        byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  part_e       part_q, part_d;
  logic [1:0]  step_q, step_d;
  logic [15:0] timer_q, timer_d;
  logic        clk_lvl_q, clk_lvl_d;
  logic        dio_lvl_q, dio_lvl_d;

  logic        out_valid_q;
  logic        acc_q, acc_d;
  logic        done_q, done_d;

  logic        take;
  logic        clear_vals;
  digit_t      h_tens, h_ones, m_tens, m_ones;
  logic [15:0] limit;
  logic [16:0] timer_inc;
  logic [1:0]  pos;
  logic [7:0]  cur_byte;
  logic [7:0]  seg_byte;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign clear_vals = hours_i[7] || minutes_i[7];

  cdw_bcd u_bcd_hours (
    .value_i (hours_i),
    .clear_i (clear_vals),
    .tens_o  (h_tens),
    .ones_o  (h_ones)
  );

  cdw_bcd u_bcd_minutes (
    .value_i (minutes_i),
    .clear_i (clear_vals),
    .tens_o  (m_tens),
    .ones_o  (m_ones)
  );

  assign limit = (tpp_q == 16'd0) ? 16'd1 : tpp_q;
  assign timer_inc = {1'b0, timer_q} + 17'd1;
  assign pos = 2'(frame_q - 3'd1);

  always_comb begin
    seg_byte = seg_of(digit_q[pos]);
    if (pos == 2'd1 && point_q) begin
      seg_byte = seg_byte | POINT_BIT;
    end
    if (frame_q == 3'd0) begin
      cur_byte = CMD_DATA;
    end else if (frame_q >= 3'd5) begin
      cur_byte = CMD_DISP | {5'b00000, bright_q};
    end else if (!byte_q) begin
      cur_byte = ADDR_BASE + {6'b000000, pos};
    end else begin
      cur_byte = seg_byte;
    end
  end

  always_comb begin
    digit_d = digit_q;
    point_d = point_q;
    active_d = active_q;
    frame_d = frame_q;
    byte_d = byte_q;
    bit_d = bit_q;
    part_d = part_q;
    step_d = step_q;
    timer_d = timer_q;
    clk_lvl_d = clk_lvl_q;
    dio_lvl_d = dio_lvl_q;
    acc_d = 1'b0;
    done_d = 1'b0;

    if (take && opcode_i == OP_SHOW) begin
      if (!active_q) begin
        digit_d[0] = h_tens;
        digit_d[1] = h_ones;
        digit_d[2] = m_tens;
        digit_d[3] = m_ones;
        point_d = dp_on_i;
        active_d = 1'b1;
        frame_d = 3'd0;
        byte_d = 1'b0;
        bit_d = 3'd0;
        part_d = PART_START;
        step_d = 2'd0;
        timer_d = 16'd0;
        acc_d = 1'b1;
      end
    end else if (take && active_q) begin
      if (part_q == PART_WAIT) begin
        if (!dio_in_i) begin
          step_d = 2'd0;
          timer_d = 16'd0;
          if (!byte_q && frame_q >= 3'd1 && frame_q <= 3'd4) begin
            byte_d = 1'b1;
            bit_d = 3'd0;
            part_d = PART_BITS;
          end else begin
            part_d = PART_STOP;
          end
        end
      end else begin
        // pin action on the first tick of a phase
        if (timer_q == 16'd0) begin
          case (part_q)
            PART_START: begin
              if (step_q == 2'd0) begin
                clk_lvl_d = 1'b1;
                dio_lvl_d = 1'b1;
              end else if (step_q == 2'd1) begin
                dio_lvl_d = 1'b0;
              end else begin
                clk_lvl_d = 1'b0;
              end
            end
            PART_BITS: begin
              if (step_q == 2'd0) begin
                clk_lvl_d = 1'b0;
              end else if (step_q == 2'd1) begin
                dio_lvl_d = cur_byte[bit_q];
              end else begin
                clk_lvl_d = 1'b1;
              end
            end
            PART_ACK: begin
              if (step_q == 2'd0) begin
                clk_lvl_d = 1'b0;
              end else if (step_q == 2'd1) begin
                dio_lvl_d = 1'b1;
              end else begin
                clk_lvl_d = 1'b1;
              end
            end
            default: begin
              if (step_q == 2'd0) begin
                clk_lvl_d = 1'b0;
              end else if (step_q == 2'd1) begin
                dio_lvl_d = 1'b0;
              end else if (step_q == 2'd2) begin
                clk_lvl_d = 1'b1;
              end else begin
                dio_lvl_d = 1'b1;
              end
            end
          endcase
        end

        if (timer_inc >= {1'b0, limit}) begin
          timer_d = 16'd0;
          case (part_q)
            PART_START: begin
              if (step_q < 2'd2) begin
                step_d = step_q + 2'd1;
              end else begin
                step_d = 2'd0;
                bit_d = 3'd0;
                part_d = PART_BITS;
              end
            end
            PART_BITS: begin
              if (step_q < 2'd2) begin
                step_d = step_q + 2'd1;
              end else begin
                step_d = 2'd0;
                if (bit_q == 3'd7) begin
                  bit_d = 3'd0;
                  part_d = PART_ACK;
                end else begin
                  bit_d = bit_q + 3'd1;
                end
              end
            end
            PART_ACK: begin
              if (step_q < 2'd2) begin
                step_d = step_q + 2'd1;
              end else begin
                step_d = 2'd0;
                part_d = PART_WAIT;
              end
            end
            default: begin
              if (step_q < 2'd3) begin
                step_d = step_q + 2'd1;
              end else begin
                step_d = 2'd0;
                byte_d = 1'b0;
                bit_d = 3'd0;
                part_d = PART_START;
                if (frame_q >= 3'(FRAME_COUNT - 1)) begin
                  frame_d = 3'd0;
                  active_d = 1'b0;
                  done_d = 1'b1;
                end else begin
                  frame_d = frame_q + 3'd1;
                end
              end
            end
          endcase
        end else begin
          timer_d = timer_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= 3'd2;
      tpp_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BRIGHTNESS: bright_q <= cfg_wdata_i[2:0];
        REG_TICKS:      tpp_q <= cfg_wdata_i;
        default:        tpp_q <= tpp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_q[i] <= '0;
      end
      point_q <= 1'b0;
      active_q <= 1'b0;
      frame_q <= 3'd0;
      byte_q <= 1'b0;
      bit_q <= 3'd0;
      part_q <= PART_START;
      step_q <= 2'd0;
      timer_q <= 16'd0;
      clk_lvl_q <= 1'b1;
      dio_lvl_q <= 1'b1;
    end else begin
      digit_q <= digit_d;
      point_q <= point_d;
      active_q <= active_d;
      frame_q <= frame_d;
      byte_q <= byte_d;
      bit_q <= bit_d;
      part_q <= part_d;
      step_q <= step_d;
      timer_q <= timer_d;
      clk_lvl_q <= clk_lvl_d;
      dio_lvl_q <= dio_lvl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q <= acc_d;
      done_q <= done_d;
    end
  end

  logic clk_res_q, dio_res_q, busy_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      clk_res_q <= clk_lvl_d;
      dio_res_q <= dio_lvl_d;
      busy_q <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clk_out_o = clk_res_q;
  assign dio_out_o = dio_res_q;
  assign busy_res_o = busy_q;
  assign accepted_o = acc_q;
  assign done_res_o = done_q;

endmodule

@@ hdl/cdw_checker.sv @@
// Port-level checker for the clock-digit display writer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cdw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic clk_out_o,
  input logic dio_out_o,
  input logic busy_res_o,
  input logic accepted_o,
  input logic done_res_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NOW(a_acc_not_done, clk_i, rst_ni, out_valid_o && accepted_o, !done_res_o)
  `ASSERT_NOW(a_acc_busy, clk_i, rst_ni, out_valid_o && accepted_o, busy_res_o)
  `ASSERT_NOW(a_done_idle, clk_i, rst_ni, out_valid_o && done_res_o,
              !busy_res_o && clk_out_o && dio_out_o)

endmodule

bind clock_digits_two_wire_display_writer_top cdw_checker u_cdw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .clk_out_o   (clk_out_o),
  .dio_out_o   (dio_out_o),
  .busy_res_o  (busy_res_o),
  .accepted_o  (accepted_o),
  .done_res_o  (done_res_o)
);
